/* hw/rtl/segment_intersection_test_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the segment intersection test
// Concurrent checks clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_TEST_ASSERT_SVH
`define SEGMENT_INTERSECTION_TEST_ASSERT_SVH

// Same-cycle implication
`define SIT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SIT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/sit_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection test package
// Shared types and fixed constants of the segment intersection pipeline.
// ----------------------------------------------------------------------------
package sit_pkg;

  // Number of orientation tests and exact products they need
  localparam int NUM_CROSS = 5;
  localparam int NUM_PROD  = 2 * NUM_CROSS;

  // Result bus width (one flag, padded to a byte)
  localparam int OUT_TDATA_W = 8;

  // Stage load enables handed to the product pipeline
  typedef struct packed {
    logic pp;    // partial products
    logic ps;    // partial sums
    logic prod;  // full product
  } sit_adv_t;

endpackage

/* hw/rtl/sit_smul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exact signed multiplier, three stages
// Splits both operands into halves, registers the four partial products,
// folds the cross terms, then forms the full 2*W-bit product.
// ----------------------------------------------------------------------------
module sit_smul #(
  parameter int W = 33
) (
  input  logic                    clk,
  input  sit_pkg::sit_adv_t       adv,
  input  logic signed [W-1:0]     a,
  input  logic signed [W-1:0]     b,
  output logic signed [2*W-1:0]   p
);

  localparam int L = (W + 1) / 2;
  localparam int H = W - L;

  logic        [L-1:0]     al, bl;
  logic signed [H-1:0]     ah, bh;
  logic        [2*L-1:0]   pll;
  logic signed [2*H-1:0]   phh;
  logic signed [H+L:0]     phl, plh;
  logic signed [2*W-1:0]   t1;
  logic signed [H+L+1:0]   t2;
  logic signed [2*W-1:0]   t2x;

  // Split operands: low halves unsigned, high halves signed
  assign al = a[L-1:0];
  assign bl = b[L-1:0];
  assign ah = $signed(a[W-1:L]);
  assign bh = $signed(b[W-1:L]);

  // Register the four partial products
  always_ff @(posedge clk) begin
    if (adv.pp) begin
      pll <= al * bl;
      phh <= ah * bh;
      phl <= ah * $signed({1'b0, bl});
      plh <= bh * $signed({1'b0, al});
    end
  end

  // Place outer terms side by side, add the cross terms
  always_ff @(posedge clk) begin
    if (adv.ps) begin
      t1 <= {phh, pll};
      t2 <= $signed({phl[H+L], phl}) + $signed({plh[H+L], plh});
    end
  end

  // Align cross sum and form the exact product
  assign t2x = (2*W)'(t2);

  always_ff @(posedge clk) begin
    if (adv.prod) begin
      p <= t1 + (t2x <<< L);
    end
  end

endmodule

/* hw/rtl/segment_intersection_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection test
// Reports whether closed segment A (ax,ay)-(bx,by) and closed segment B
// (cx,cy)-(dx,dy) share a point, using exact orientation tests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: eight signed coordinates packed in
//   s_axis_tdata, ax in the lowest COORD_BITS. Each request gives one result
//   on the m_axis channel, bit 0 of m_axis_tdata set when the segments meet.
//   A new request can be taken every cycle while s_axis_tready is high; it
//   passes through the six-stage pipeline (differences, partial products,
//   partial sums, products, compares, result), whose stages each load
//   whenever they are empty or drain.
//   When the receiver stalls, the result register holds and stages behind
//   it fill up; s_axis_tready drops only once every stage holds a request.
//   Bubbles inside the pipeline are squeezed out during a stall.
//   Reset clears all stage valid bits; no results are pending afterwards.
// ----------------------------------------------------------------------------
`include "segment_intersection_test_assert.svh"

module segment_intersection_test #(
  parameter int COORD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // ax, ay, bx, by_coord, cx, cy, dx, dy (COORD_BITS each, lowest first)
  input  logic [8*COORD_BITS-1:0]         s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // intersects (bit 0), zero padding above
  output logic [sit_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int CB     = COORD_BITS;
  localparam int W      = COORD_BITS + 1;
  localparam int STAGES = 6;
  localparam int NC     = sit_pkg::NUM_CROSS;
  localparam int NP     = sit_pkg::NUM_PROD;

  logic signed [CB-1:0]  ax, ay, bx, by_coord, cx, cy, dx, dy;
  logic [STAGES-1:0]     v;
  logic [STAGES:0]       en;
  sit_pkg::sit_adv_t     adv;

  logic signed [W-1:0]   bax, bay, cax, cay, dax, day;
  logic signed [W-1:0]   dcx, dcy, acx, acy, bcx, bcy;
  logic                  box_fail;
  logic                  box_s1, box_s2, box_s3, box_s4, box_s5;

  logic signed [W-1:0]   px [NC];
  logic signed [W-1:0]   py [NC];
  logic signed [W-1:0]   qx [NC];
  logic signed [W-1:0]   qy [NC];
  logic signed [W-1:0]   mul_a [NP];
  logic signed [W-1:0]   mul_b [NP];
  logic signed [2*W-1:0] mul_p [NP];

  logic [NC-1:0]         gt, lt;
  logic                  apart1, apart2, parallel, hit;
  logic                  intersects;

  // Unpack coordinates
  assign ax       = s_axis_tdata[0*CB +: CB];
  assign ay       = s_axis_tdata[1*CB +: CB];
  assign bx       = s_axis_tdata[2*CB +: CB];
  assign by_coord = s_axis_tdata[3*CB +: CB];
  assign cx       = s_axis_tdata[4*CB +: CB];
  assign cy       = s_axis_tdata[5*CB +: CB];
  assign dx       = s_axis_tdata[6*CB +: CB];
  assign dy       = s_axis_tdata[7*CB +: CB];

  // Stage enables: a stage loads when empty or when the next one loads
  always_comb begin
    en[STAGES] = m_axis_tready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];
  assign adv.pp        = en[1];
  assign adv.ps        = en[2];
  assign adv.prod      = en[3];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Bounding boxes apart on some axis in either direction
  assign box_fail =
      (ax < cx && ax < dx && bx < cx && bx < dx) ||
      (ay < cy && ay < dy && by_coord < cy && by_coord < dy) ||
      (cx < ax && cx < bx && dx < ax && dx < bx) ||
      (cy < ay && cy < by_coord && dy < ay && dy < by_coord);

  // Stage 1: coordinate differences and box flag
  always_ff @(posedge clk) begin
    if (en[0]) begin
      bax    <= W'(bx) - W'(ax);
      bay    <= W'(by_coord) - W'(ay);
      cax    <= W'(cx) - W'(ax);
      cay    <= W'(cy) - W'(ay);
      dax    <= W'(dx) - W'(ax);
      day    <= W'(dy) - W'(ay);
      dcx    <= W'(dx) - W'(cx);
      dcy    <= W'(dy) - W'(cy);
      acx    <= W'(ax) - W'(cx);
      acy    <= W'(ay) - W'(cy);
      bcx    <= W'(bx) - W'(cx);
      bcy    <= W'(by_coord) - W'(cy);
      box_s1 <= !box_fail;
    end
  end

  // Carry box flag alongside the product stages
  always_ff @(posedge clk) begin
    if (en[1]) begin
      box_s2 <= box_s1;
    end
    if (en[2]) begin
      box_s3 <= box_s2;
    end
    if (en[3]) begin
      box_s4 <= box_s3;
    end
    if (en[4]) begin
      box_s5 <= box_s4;
    end
  end

  // Orientation tests: C and D against A, A and B against B, A against B
  assign px[0] = bax;  assign py[0] = bay;  assign qx[0] = cax;  assign qy[0] = cay;
  assign px[1] = bax;  assign py[1] = bay;  assign qx[1] = dax;  assign qy[1] = day;
  assign px[2] = dcx;  assign py[2] = dcy;  assign qx[2] = acx;  assign qy[2] = acy;
  assign px[3] = dcx;  assign py[3] = dcy;  assign qx[3] = bcx;  assign qy[3] = bcy;
  assign px[4] = bax;  assign py[4] = bay;  assign qx[4] = dcx;  assign qy[4] = dcy;

  // Stages 2 to 4: exact products p.x*q.y and p.y*q.x
  for (genvar i = 0; i < NC; i++) begin : g_cross
    assign mul_a[2*i]   = px[i];
    assign mul_b[2*i]   = qy[i];
    assign mul_a[2*i+1] = py[i];
    assign mul_b[2*i+1] = qx[i];
  end

  for (genvar j = 0; j < NP; j++) begin : g_mul
    sit_smul #(
      .W (W)
    ) u_mul (
      .clk (clk),
      .adv (adv),
      .a   (mul_a[j]),
      .b   (mul_b[j]),
      .p   (mul_p[j])
    );
  end

  // Stage 5: cross product signs
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < NC; i++) begin
        gt[i] <= mul_p[2*i] > mul_p[2*i+1];
        lt[i] <= mul_p[2*i] < mul_p[2*i+1];
      end
    end
  end

  // Combine side tests; parallel or degenerate pairs also need box overlap
  assign apart1   = (gt[0] && gt[1]) || (lt[0] && lt[1]);
  assign apart2   = (gt[2] && gt[3]) || (lt[2] && lt[3]);
  assign parallel = !gt[4] && !lt[4];
  assign hit      = !apart1 && !apart2 && (!parallel || box_s5);

  // Stage 6: result register
  always_ff @(posedge clk) begin
    if (en[5]) begin
      intersects <= hit;
    end
  end

  assign m_axis_tvalid = v[STAGES-1];
  assign m_axis_tdata  = {{(sit_pkg::OUT_TDATA_W - 1){1'b0}}, intersects};

  // Checks
  `SIT_ASSERT_NOW(a_full_when_blocked, !s_axis_tready, &v, "input blocked with a free stage")
  `SIT_ASSERT_NEXT(a_accept_lands, s_axis_tvalid && s_axis_tready, v[0], "accepted request lost")
  `SIT_ASSERT_NEXT(a_held_stage_keeps, v[3] && !en[3], v[3], "stalled stage dropped its request")
  `SIT_ASSERT_NOW(a_sign_exclusive, v[4], (gt & lt) == '0, "cross product both positive and negative")

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection test bench
// Streams segment pairs into the block and checks every intersects flag
// against an exact orientation predictor kept in this bench. Covers
// crossings, touching ends, zero-length and collinear segments, extreme
// coordinates and random geometry, with random gaps and stalls on both
// streams.
// ----------------------------------------------------------------------------
module tb;

  localparam int COORD_BITS  = 32;
  localparam int HIT_BIT     = 0;
  localparam int WATCHDOG    = 1000;
  localparam int DRAIN_TAIL  = 12;
  localparam int MAX_PRINTS  = 40;
  localparam int C_MAX       = 32'sh7fff_ffff;
  localparam int C_MIN       = 32'sh8000_0000;

  // One request: ax lowest, dy highest
  typedef struct packed {
    logic signed [COORD_BITS-1:0] dy;
    logic signed [COORD_BITS-1:0] dx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] by_coord;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] ax;
  } seg_query_t;

  typedef struct {
    logic signed [63:0] x;
    logic signed [63:0] y;
  } point_t;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    int   idx;
    logic hit;
  } hit_entry_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [8*COORD_BITS-1:0] s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [sit_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  hit_entry_t expected_hits[$];
  int         mismatch_count = 0;
  int         accepted_count = 0;
  bit         no_idle = 1'b0;

  always #5 clk = ~clk;

  segment_intersection_test #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic point_t pt_diff(point_t p, point_t q);
    point_t r;
    r.x = p.x - q.x;
    r.y = p.y - q.y;
    return r;
  endfunction

  // Sign of p.x*q.y - p.y*q.x, exact
  function automatic int turn_sign(point_t p, point_t q);
    wide_t px, py, qx, qy, cr;
    px = p.x;
    py = p.y;
    qx = q.x;
    qy = q.y;
    cr = px * qy - py * qx;
    if (cr < 0) return -1;
    if (cr == 0) return 0;
    return 1;
  endfunction

  // False when r and s sit strictly on the same side of line p-q
  function automatic bit not_one_side(point_t p, point_t q, point_t r, point_t s);
    point_t d;
    int s1, s2;
    d  = pt_diff(q, p);
    s1 = turn_sign(d, pt_diff(r, p));
    s2 = turn_sign(d, pt_diff(s, p));
    return !((s1 > 0 && s2 > 0) || (s1 < 0 && s2 < 0));
  endfunction

  function automatic logic signed [63:0] max64(logic signed [63:0] a,
                                               logic signed [63:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [63:0] min64(logic signed [63:0] a,
                                               logic signed [63:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic bit boxes_reach(point_t p, point_t q, point_t r, point_t s);
    return !(max64(p.x, q.x) < min64(r.x, s.x) || max64(p.y, q.y) < min64(r.y, s.y));
  endfunction

  function automatic logic predict_intersects(seg_query_t q);
    point_t a, b, c, d;
    bit hit;
    a.x = q.ax;  a.y = q.ay;
    b.x = q.bx;  b.y = q.by_coord;
    c.x = q.cx;  c.y = q.cy;
    d.x = q.dx;  d.y = q.dy;
    hit = not_one_side(a, b, c, d) && not_one_side(c, d, a, b);
    // Parallel or degenerate: boxes must overlap too
    if (hit && turn_sign(pt_diff(b, a), pt_diff(d, c)) == 0)
      hit = boxes_reach(a, b, c, d) && boxes_reach(c, d, a, b);
    return hit;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking and watchdog
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // Record each accepted request, then compare each accepted result
  always @(posedge clk) begin
    hit_entry_t e;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        e.idx = accepted_count;
        e.hit = predict_intersects(seg_query_t'(s_axis_tdata));
        expected_hits.push_back(e);
        accepted_count++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_hits.size() == 0) begin
          report_mismatch($sformatf("result 0x%02h with no request pending", m_axis_tdata));
        end else begin
          e = expected_hits.pop_front();
          if (m_axis_tdata[HIT_BIT] !== e.hit)
            report_mismatch($sformatf("request %0d: intersects %0b, expected %0b",
                                      e.idx, m_axis_tdata[HIT_BIT], e.hit));
          if (m_axis_tdata[sit_pkg::OUT_TDATA_W-1:1] !== '0)
            report_mismatch($sformatf("request %0d: padding bits 0x%02h not zero",
                                      e.idx, m_axis_tdata[sit_pkg::OUT_TDATA_W-1:1]));
        end
      end
    end
  end

  // End the run when neither stream moves for too long
  always @(posedge clk) begin
    int quiet_cycles;
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready with short and occasional long stalls
  // --------------------------------------------------------------------------

  always @(negedge clk) begin
    int hold_left;
    int r;
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left = 0;
    end else if (no_idle) begin
      m_axis_tready <= 1'b1;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        m_axis_tready <= 1'b1;
        hold_left = $urandom_range(0, 6);
      end else if (r < 95) begin
        m_axis_tready <= 1'b0;
        hold_left = $urandom_range(0, 3);
      end else begin
        m_axis_tready <= 1'b0;
        hold_left = $urandom_range(15, 40);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one request and hold it until accepted
  task automatic send_query(seg_query_t q);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= q;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_for_drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic seg_query_t mk(int ax, int ay, int bx, int by_c,
                                    int cx, int cy, int dx, int dy);
    seg_query_t q;
    q.ax = ax;  q.ay = ay;  q.bx = bx;  q.by_coord = by_c;
    q.cx = cx;  q.cy = cy;  q.dx = dx;  q.dy = dy;
    return q;
  endfunction

  function automatic int rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return C_MIN;
    if (r < 6) return C_MAX;
    if (r < 8) return 0;
    if (r < 10) return -1;
    return $urandom;
  endfunction

  function automatic int small_coord();
    return int'($urandom_range(0, 8)) - 4;
  endfunction

  function automatic int small_step(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Pairs built on a random line: collinear, touching, degenerate, offset
  function automatic seg_query_t structured_query();
    int px, py, vx, vy, t1, t2, t3, t4, kind;
    int ox, oy;
    seg_query_t q;
    px = int'($urandom_range(0, 32'h7fff_ffff)) - 32'sh4000_0000;
    py = int'($urandom_range(0, 32'h7fff_ffff)) - 32'sh4000_0000;
    vx = small_step($urandom_range(0, 1) ? 3 : 1000);
    vy = small_step($urandom_range(0, 1) ? 3 : 1000);
    t1 = small_step(20);
    t2 = small_step(20);
    t3 = small_step(20);
    t4 = small_step(20);
    ox = small_step(1000);
    oy = small_step(1000);
    kind = $urandom_range(0, 5);
    q = mk(px + t1 * vx, py + t1 * vy, px + t2 * vx, py + t2 * vy,
           px + t3 * vx, py + t3 * vy, px + t4 * vx, py + t4 * vy);
    case (kind)
      // B collapsed to a point on A's line
      1: begin
        q.dx = q.cx;
        q.dy = q.cy;
      end
      // A collapsed to a point on B's line
      2: begin
        q.bx = q.ax;
        q.by_coord = q.ay;
      end
      // B starts where A ends
      3: begin
        q.cx = q.bx;
        q.cy = q.by_coord;
        q.dx = q.bx + ox;
        q.dy = q.by_coord + oy;
      end
      // B on a line shifted by one unit
      4: begin
        if ($urandom_range(0, 1)) begin
          q.cx = q.cx + 1;
          q.dx = q.dx + 1;
        end else begin
          q.cy = q.cy + 1;
          q.dy = q.dy + 1;
        end
      end
      // B ends on A's line, other end off it
      5: begin
        q.dx = q.cx + ox;
        q.dy = q.cy + oy;
      end
      default: ;
    endcase
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic test_directed();
    // Proper crossing, parallel apart, T junction, T just short of A
    send_query(mk(0, 0, 10, 10, 0, 10, 10, 0));
    send_query(mk(0, 0, 10, 0, 0, 1, 10, 1));
    send_query(mk(0, 0, 10, 0, 5, 0, 5, 5));
    send_query(mk(0, 0, 10, 0, 5, 1, 5, 5));
    // Zero-length first segment: on B, on B's line past its box, off line
    send_query(mk(5, 5, 5, 5, 0, 0, 10, 10));
    send_query(mk(20, 20, 20, 20, 0, 0, 10, 10));
    send_query(mk(5, 6, 5, 6, 0, 0, 10, 10));
    // Zero-length second segment: on A, past A's box
    send_query(mk(0, 0, 10, 10, 10, 10, 10, 10));
    send_query(mk(0, 0, 10, 10, -1, -1, -1, -1));
    // Both zero-length: equal and distinct points
    send_query(mk(3, -4, 3, -4, 3, -4, 3, -4));
    send_query(mk(3, -4, 3, -4, 3, -5, 3, -5));
    // Collinear: overlapping, touching at an end, apart
    send_query(mk(0, 0, 10, 0, 5, 0, 20, 0));
    send_query(mk(0, 0, 10, 0, 10, 0, 20, 0));
    send_query(mk(0, 0, 10, 0, 11, 0, 20, 0));
    send_query(mk(0, 0, 0, 10, 0, -5, 0, -1));
    // Extreme coordinates
    send_query(mk(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN));
    send_query(mk(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN + 1, C_MIN, C_MAX, C_MAX - 1));
    send_query(mk(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN + 1, C_MAX, C_MAX));
    send_query(mk(C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
    send_query(mk(C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN));
    send_query(mk(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
    send_query(mk(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
    send_query(mk(-1, -1, -1, -1, 0, 0, 0, 0));
    send_query(mk(C_MIN, 0, C_MAX, 0, 0, C_MIN, 0, C_MAX));
  endtask

  task automatic test_random_full_range(int count);
    repeat (count)
      send_query(mk(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord(), rand_coord()));
  endtask

  task automatic test_random_small_grid(int count);
    repeat (count)
      send_query(mk(small_coord(), small_coord(), small_coord(), small_coord(),
                    small_coord(), small_coord(), small_coord(), small_coord()));
  endtask

  task automatic test_random_on_line(int count);
    repeat (count) send_query(structured_query());
  endtask

  // Pause the sender until every result is back, then resume
  task automatic test_pause_and_resume();
    test_random_small_grid(40);
    wait_for_drain();
    test_random_on_line(40);
  endtask

  // Full rate with the receiver always ready
  task automatic test_back_to_back();
    wait_for_drain();
    no_idle = 1'b1;
    test_random_on_line(60);
    wait_for_drain();
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_full_range(200);
    test_random_small_grid(260);
    test_random_on_line(220);
    test_pause_and_resume();
    test_back_to_back();

    wait_for_drain();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatch_count == 0 && expected_hits.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
